>>> rtl/core/sha512_block_compression_defines.svh
// Assertion macros for the SHA-512 block compression core.
`ifndef SHA512_BLOCK_COMPRESSION_DEFINES_SVH
`define SHA512_BLOCK_COMPRESSION_DEFINES_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHA_NEVER(label, clk, rst_n, cond, msg) \
    `SHA_ASSERT(label, clk, rst_n, !(cond), msg)
`else
`define SHA_ASSERT(label, clk, rst_n, prop, msg)
`define SHA_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/core/sha512_pkg.sv
// Package: SHA-512 constants, state type and round functions.
`timescale 1ns / 1ps
`default_nettype none
package sha512_pkg;
    localparam int ROUNDS = 80;
    localparam int RND_W = 7;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef logic [63:0] word_t;

    localparam word_t INIT_HASH [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2170
    };

    localparam word_t ROUND_CONST [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic word_t big_sig0(input word_t x);
        big_sig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic word_t big_sig1(input word_t x);
        big_sig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic word_t sml_sig0(input word_t x);
        sml_sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic word_t sml_sig1(input word_t x);
        sml_sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/sha512_round.sv
// One SHA-512 round and schedule step, shared over all 80 rounds.
`timescale 1ns / 1ps
`default_nettype none
module sha512_round
    import sha512_pkg::*;
(
    input  wire word_t            vars   [8],
    input  wire word_t            win    [16],
    input  wire logic [RND_W-1:0] rnd,
    output word_t                 vars_n [8],
    output word_t                 w_out
);
    word_t w;
    word_t t1;
    word_t t2;
    word_t a;
    word_t b;
    word_t c;
    word_t e;
    word_t f;
    word_t g;

    always_comb
    begin
        a = vars[0];
        b = vars[1];
        c = vars[2];
        e = vars[4];
        f = vars[5];
        g = vars[6];
        if (rnd < RND_W'(16))
        begin
            w = win[0];
        end
        else
        begin
            w = sml_sig1(win[14]) + win[9] + sml_sig0(win[1]) + win[0];
        end
        t1 = vars[7] + big_sig1(e) + ((e & f) ^ (~e & g)) + ROUND_CONST[rnd] + w;
        t2 = big_sig0(a) + ((a & b) ^ (a & c) ^ (b & c));
        vars_n[7] = g;
        vars_n[6] = f;
        vars_n[5] = e;
        vars_n[4] = vars[3] + t1;
        vars_n[3] = c;
        vars_n[2] = b;
        vars_n[1] = a;
        vars_n[0] = t1 + t2;
        w_out = w;
    end
endmodule
`default_nettype wire

>>> rtl/core/sha512_block_compression.sv
// Top level: SHA-512 block compression over a word stream.
// Channel | dir | tdata                 | tuser
// s_axis  | in  | message_word[63:0]    | first_of_message
// m_axis  | out | digest_word[63:0]     | digest_index[2:0]; tlast = last_of_digest
// Sixteen words are taken one per cycle; the sixteenth starts 80 rounds
// through the shared round unit, then the add step, then eight
// output words, one per accepted request. Input is not ready meanwhile.
// Reset restores the initial hash values.
`timescale 1ns / 1ps
`default_nettype none
`include "sha512_block_compression_defines.svh"
module sha512_block_compression
    import sha512_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // message_word
    input  wire logic        s_axis_tuser,  // first_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata,  // digest_word
    output logic      [2:0]  m_axis_tuser,  // digest_index
    output logic             m_axis_tlast
);
    state_t           state_reg, state_next;
    word_t            chain_reg [8];
    word_t            vars_reg  [8];
    word_t            win_reg   [16];
    word_t            vars_n    [8];
    word_t            w_out;
    logic [3:0]       cnt_reg;
    logic [RND_W-1:0] rnd_reg;
    logic [2:0]       oidx_reg;
    logic             in_acc;
    logic             out_acc;
    logic             first_block;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign first_block = in_acc && s_axis_tuser;

    sha512_round u_round (
        .vars   (vars_reg),
        .win    (win_reg),
        .rnd    (rnd_reg),
        .vars_n (vars_n),
        .w_out  (w_out)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_acc && (s_axis_tuser ? 4'd0 : cnt_reg) == 4'd15)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rnd_reg == RND_W'(ROUNDS - 1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_acc && oidx_reg == 3'd7)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_COLLECT);
        m_axis_tvalid = (state_reg == ST_EMIT);
        m_axis_tdata  = chain_reg[oidx_reg];
        m_axis_tuser  = oidx_reg;
        m_axis_tlast  = (oidx_reg == 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            cnt_reg   <= 4'd0;
            rnd_reg   <= '0;
            oidx_reg  <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_COLLECT:
                begin
                    if (in_acc)
                    begin
                        cnt_reg <= (s_axis_tuser ? 4'd0 : cnt_reg) + 4'd1;
                        rnd_reg <= '0;
                        if (first_block)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                chain_reg[i] <= INIT_HASH[i];
                            end
                        end
                    end
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + RND_W'(1);
                end
                ST_ADD:
                begin
                    oidx_reg <= 3'd0;
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + vars_reg[i];
                    end
                end
                ST_EMIT:
                begin
                    if (out_acc)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                    end
                end
                default:
                begin
                    cnt_reg <= 4'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COLLECT)
        begin
            if (in_acc)
            begin
                // shift window so word 0 sits lowest after sixteen words
                for (int i = 0; i < 15; i++)
                begin
                    win_reg[i] <= win_reg[i + 1];
                end
                win_reg[15] <= s_axis_tdata;
                if ((s_axis_tuser ? 4'd0 : cnt_reg) == 4'd15)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        vars_reg[i] <= first_block ? INIT_HASH[i] : chain_reg[i];
                    end
                end
            end
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_out;
            vars_reg <= vars_n;
        end
    end

    `SHA_NEVER(a_ready_idle, clk, rst_n, s_axis_tready && m_axis_tvalid, "ready while emitting")
    `SHA_ASSERT(a_round_cnt, clk, rst_n,
        (state_reg == ST_ROUND) |-> (rnd_reg < RND_W'(ROUNDS)), "round overrun")
    `SHA_ASSERT(a_emit_start, clk, rst_n, $rose(m_axis_tvalid) |-> (m_axis_tuser == 3'd0), "emit not from word 0")
endmodule
`default_nettype wire
